FILE: hw/rtl/pto_pkg.sv
// Package for the peer time offset median unit: sizes, reset values, codes and types.
`default_nettype none

package pto_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int TIME_W      = 36;
    localparam int OFS_W       = 37;
    localparam int MIN_W       = 9;
    localparam int OUT_CNT_W   = 9;
    localparam int CMP_W       = (CNT_W > MIN_W) ? CNT_W : MIN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 48;

    localparam logic [TIME_W-1:0] MAX_OFFSET_RST  = TIME_W'(70 * 60);
    localparam logic [TIME_W-1:0] NEAR_OFFSET_RST = TIME_W'(5 * 60);
    localparam logic [MIN_W-1:0]  MIN_SAMPLES_RST = MIN_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_OFFSET  = 2'd0,
        CFG_NEAR_OFFSET = 2'd1,
        CFG_MIN_SAMPLES = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_INS,
        ST_POST,
        ST_MED,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic gt;
        logic mag_lt;
        logic nonzero;
    } t_cmp_res;

endpackage

`default_nettype wire

FILE: hw/rtl/pto_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pto_cmp.sv
// Shared compare unit: ordering against the sample and magnitude against a limit.
`default_nettype none

module pto_cmp
    import pto_pkg::*;
(
    input  wire logic signed [OFS_W-1:0]  i_entry,
    input  wire logic signed [OFS_W-1:0]  i_sample,
    input  wire logic        [TIME_W-1:0] i_limit,
    output t_cmp_res                      o_res
);

    logic [OFS_W-1:0] mag;

    always_comb begin
        mag           = i_entry[OFS_W-1] ? (OFS_W'(0) - i_entry) : i_entry;
        o_res.gt      = i_entry > i_sample;
        o_res.mag_lt  = mag < {1'b0, i_limit};
        o_res.nonzero = i_entry != '0;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/peer_time_offset_median_unit.sv
// Top level of the peer time offset median unit: sequencer, state and stream ports.
//
//   channel   direction  handshake                 payload
//   s_axis    in         i_s_tvalid / o_s_tready   i_s_tdata: peer_time, local_time
//   m_axis    out        o_m_tvalid / i_m_tready   o_m_tdata: warning, time_offset,
//                                                  count, full_res
//   cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item on a full store skips the insertion; otherwise the insertion shift and the agreement
// scan each step through the offset RAM one entry per cycle.
// Reset clears the count, the warned flag, the offset and the registers to their defaults.
// The RAM contents are not cleared; only written entries are read.
// The output register holds one finished word, so the next word may be taken while it waits.
`default_nettype none

module peer_time_offset_median_unit
    import pto_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [35:0] peer_time, [71:36] local_time
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [0] warning, [37:1] time_offset, [46:38] count, [47] full_res
    output logic      [OUT_DATA_W-1:0] o_m_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0]     i_cfg_data
);

    t_state                   r_state, n_state;
    logic [ADDR_W-1:0]        r_pos, n_pos;
    logic [ADDR_W-1:0]        r_idx, n_idx;
    logic signed [OFS_W-1:0]  r_sample, n_sample;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_warned, n_warned;
    logic signed [OFS_W-1:0]  r_cur_offset, n_cur_offset;
    logic                     r_item_warn, n_item_warn;
    logic                     r_item_full, n_item_full;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_warn, n_out_warn;
    logic signed [OFS_W-1:0]  r_out_offset, n_out_offset;
    logic [CNT_W-1:0]         r_out_count, n_out_count;
    logic                     r_out_full, n_out_full;
    logic [TIME_W-1:0]        r_max_offset;
    logic [TIME_W-1:0]        r_near_offset;
    logic [MIN_W-1:0]         r_min_samples;

    logic                     s_accept;
    logic                     out_free;
    logic [CNT_W-1:0]         count_inc;
    logic                     apply_median;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic signed [OFS_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic signed [OFS_W-1:0]  ram_rdata;
    logic [TIME_W-1:0]        cmp_limit;
    t_cmp_res                 cmp_res;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign count_inc   = r_count + CNT_W'(1);
    assign apply_median = (CMP_W'(count_inc) >= CMP_W'(r_min_samples)) && count_inc[0];
    assign cmp_limit   = (r_state == ST_SCAN) ? r_near_offset : r_max_offset;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_full, OUT_CNT_W'(r_out_count), r_out_offset, r_out_warn};

    pto_ram #(
        .WIDTH (OFS_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pto_cmp u_cmp (
        .i_entry  (ram_rdata),
        .i_sample (r_sample),
        .i_limit  (cmp_limit),
        .o_res    (cmp_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (r_count >= CNT_W'(MAX_SAMPLES)) begin
                        n_state = ST_DONE;
                    end else if (r_count == '0) begin
                        n_state = ST_INS;
                    end else begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (!cmp_res.gt) begin
                    n_state = ST_POST;
                end else if (r_pos == ADDR_W'(1)) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                n_state = apply_median ? ST_MED : ST_DONE;
            end
            ST_MED: begin
                if (!cmp_res.mag_lt && !r_warned) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if ((cmp_res.nonzero && cmp_res.mag_lt)
                    || (CNT_W'(r_idx) + CNT_W'(1) == r_count)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_sample     = r_sample;
        n_count      = r_count;
        n_warned     = r_warned;
        n_cur_offset = r_cur_offset;
        n_item_warn  = r_item_warn;
        n_item_full  = r_item_full;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_warn   = r_out_warn;
        n_out_offset = r_out_offset;
        n_out_count  = r_out_count;
        n_out_full   = r_out_full;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_sample;
        ram_raddr    = r_pos - ADDR_W'(2);
        case (r_state)
            ST_IDLE: begin
                n_sample    = {1'b0, i_s_tdata[TIME_W-1:0]}
                              - {1'b0, i_s_tdata[2*TIME_W-1:TIME_W]};
                n_item_warn = 1'b0;
                n_item_full = r_count >= CNT_W'(MAX_SAMPLES);
                n_pos       = ADDR_W'(r_count);
                ram_raddr   = ADDR_W'(r_count - CNT_W'(1));
            end
            ST_SHIFT: begin
                ram_we = 1'b1;
                if (cmp_res.gt) begin
                    ram_wdata = ram_rdata;
                    n_pos     = r_pos - ADDR_W'(1);
                end
            end
            ST_INS: begin
                ram_we = 1'b1;
            end
            ST_POST: begin
                n_count   = count_inc;
                ram_raddr = ADDR_W'(count_inc >> 1);
            end
            ST_MED: begin
                n_idx     = '0;
                ram_raddr = '0;
                n_cur_offset = cmp_res.mag_lt ? ram_rdata : '0;
            end
            ST_SCAN: begin
                n_idx     = r_idx + ADDR_W'(1);
                ram_raddr = r_idx + ADDR_W'(1);
                if (!(cmp_res.nonzero && cmp_res.mag_lt)
                    && (CNT_W'(r_idx) + CNT_W'(1) == r_count)) begin
                    n_warned    = 1'b1;
                    n_item_warn = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_warn   = r_item_warn;
                    n_out_offset = r_cur_offset;
                    n_out_count  = r_count;
                    n_out_full   = r_item_full;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_warned      <= 1'b0;
            r_cur_offset  <= '0;
            r_out_valid   <= 1'b0;
            r_max_offset  <= MAX_OFFSET_RST;
            r_near_offset <= NEAR_OFFSET_RST;
            r_min_samples <= MIN_SAMPLES_RST;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_warned     <= n_warned;
            r_cur_offset <= n_cur_offset;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_OFFSET:  r_max_offset  <= i_cfg_data;
                    CFG_NEAR_OFFSET: r_near_offset <= i_cfg_data;
                    CFG_MIN_SAMPLES: r_min_samples <= i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_sample     <= n_sample;
        r_item_warn  <= n_item_warn;
        r_item_full  <= n_item_full;
        r_out_warn   <= n_out_warn;
        r_out_offset <= n_out_offset;
        r_out_count  <= n_out_count;
        r_out_full   <= n_out_full;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("stored count exceeds the store depth");

    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_pos != '0))
        else $error("insertion shift entered at the bottom of the store");

    a_warn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_warn) |-> (r_out_offset == '0))
        else $error("warning word carries a nonzero offset");

    a_full_no_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |-> !r_out_warn)
        else $error("dropped word raised a warning");

    a_warn_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_warned)
        else $error("agreement scan started after the warning was given");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the peer time offset median unit, with random stream stalls.
module tb_top;
    import pto_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TS_MAX = (longint'(1) << TIME_W) - 1;

    typedef struct {
        logic [TIME_W-1:0] peer_ts;
        logic [TIME_W-1:0] lcl_ts;
    } t_stamp_pair;

    typedef struct {
        logic              warn;
        logic [OFS_W-1:0]  ofs;
        logic [MIN_W-1:0]  cnt;
        logic              full;
    } t_offset_report;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index = CFG_MAX_OFFSET;
    logic [TIME_W-1:0]     cfg_data = '0;

    t_stamp_pair    pending_stamps[$];
    t_offset_report expected_reports[$];

    logic signed [OFS_W-1:0] sorted_ofs [MAX_SAMPLES];
    int                      held_cnt = 0;
    bit                      warn_given = 1'b0;
    logic signed [OFS_W-1:0] cur_ofs = '0;
    logic [TIME_W-1:0]       lim_max_ofs = MAX_OFFSET_RST;
    logic [TIME_W-1:0]       lim_near_ofs = NEAR_OFFSET_RST;
    logic [MIN_W-1:0]        lim_min_cnt = MIN_SAMPLES_RST;

    int  gap_left = 0;
    int  stall_left = 0;
    int  long_hold_left = 0;
    logic long_hold_go = 1'b0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    int words_in = 0;
    int results_checked = 0;
    int samples_stored = 0;
    int samples_dropped = 0;
    int warnings_seen = 0;
    int cfg_settings = 0;
    int bad_results = 0;

    peer_time_offset_median_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [OFS_W-1:0] ofs_mag(logic signed [OFS_W-1:0] v);
        return v[OFS_W-1] ? -v : v;
    endfunction

    task automatic apply_peer_sample(logic [TIME_W-1:0] peer, logic [TIME_W-1:0] lcl);
        t_offset_report          rep;
        logic signed [OFS_W-1:0] smp;
        logic signed [OFS_W-1:0] med;
        int                      pos;
        bit                      agree;
        rep.warn = 1'b0;
        rep.full = 1'b0;
        if (held_cnt >= MAX_SAMPLES) begin
            rep.full = 1'b1;
            samples_dropped++;
        end else begin
            smp = {1'b0, peer} - {1'b0, lcl};
            pos = held_cnt;
            while (pos > 0 && sorted_ofs[pos-1] > smp) begin
                sorted_ofs[pos] = sorted_ofs[pos-1];
                pos--;
            end
            sorted_ofs[pos] = smp;
            held_cnt++;
            samples_stored++;
            if (held_cnt >= lim_min_cnt && (held_cnt % 2) == 1) begin
                med = sorted_ofs[held_cnt / 2];
                if (ofs_mag(med) >= {1'b0, lim_max_ofs}) begin
                    if (!warn_given) begin
                        agree = 1'b0;
                        for (int i = 0; i < held_cnt; i++) begin
                            if (sorted_ofs[i] != 0
                                    && ofs_mag(sorted_ofs[i]) < {1'b0, lim_near_ofs})
                                agree = 1'b1;
                        end
                        if (!agree) begin
                            warn_given = 1'b1;
                            rep.warn = 1'b1;
                        end
                    end
                    med = '0;
                end
                cur_ofs = med;
            end
        end
        rep.ofs = cur_ofs;
        rep.cnt = MIN_W'(held_cnt);
        expected_reports.push_back(rep);
    endtask

    // Stream sender: one word per pending stamp pair, with a random gap after each unless tx_steady is set.
    always @(posedge clk) begin
        t_stamp_pair nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_peer_sample(s_tdata[TIME_W-1:0], s_tdata[2*TIME_W-1:TIME_W]);
                words_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_stamps.size() != 0) begin
                    nxt = pending_stamps.pop_front();
                    s_tdata <= {nxt.lcl_ts, nxt.peer_ts};
                    s_tvalid <= 1'b1;
                    gap_left <= tx_steady ? 0 : $urandom_range(0, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (long_hold_go)
            long_hold_left <= 400;
        else if (long_hold_left != 0)
            long_hold_left <= long_hold_left - 1;
    end

    // Result receiver and checker.
    always @(posedge clk) begin
        t_offset_report want;
        int             stall;
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            stall = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_tvalid && m_tready) begin
                results_checked++;
                stall = rx_steady ? 0 : $urandom_range(0, 10);
                if (expected_reports.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("Unexpected result word %h with no item outstanding.", m_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[0] !== want.warn || m_tdata[37:1] !== want.ofs
                            || m_tdata[46:38] !== want.cnt || m_tdata[47] !== want.full) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"Mismatch on result %0d: expected warn %b ",
                                      "offset %0d count %0d full %b, got warn %b ",
                                      "offset %0d count %0d full %b"},
                                     results_checked, want.warn, $signed(want.ofs), want.cnt,
                                     want.full, m_tdata[0], $signed(m_tdata[37:1]),
                                     m_tdata[46:38], m_tdata[47]);
                    end
                    if (m_tdata[0] === 1'b1)
                        warnings_seen++;
                end
            end
            stall_left <= stall;
            m_tready <= (stall == 0) && (long_hold_left == 0) && !long_hold_go;
        end
    end

    function automatic longint rand_upto(longint n);
        longint r;
        r = longint'({$urandom(), $urandom()} >> 1);
        return r % (n + 1);
    endfunction

    task automatic queue_stamps(logic [TIME_W-1:0] peer, logic [TIME_W-1:0] lcl);
        t_stamp_pair sp;
        sp.peer_ts = peer;
        sp.lcl_ts = lcl;
        pending_stamps.push_back(sp);
    endtask

    task automatic queue_offset(longint ofs);
        longint mag;
        longint lt;
        mag = (ofs < 0) ? -ofs : ofs;
        lt = rand_upto(TS_MAX - mag);
        if (ofs < 0)
            lt = lt + mag;
        queue_stamps(TIME_W'(lt + ofs), TIME_W'(lt));
    endtask

    task automatic queue_random_sample();
        int unsigned sel;
        longint      base;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            base = $urandom_range(0, 6000);
            queue_offset($urandom_range(0, 1) ? base : -base);
        end else if (sel < 60) begin
            base = $urandom_range(0, 300);
            queue_offset($urandom_range(0, 1) ? base : -base);
        end else if (sel < 70) begin
            queue_offset(0);
        end else if (sel < 90) begin
            queue_stamps(TIME_W'(rand_upto(TS_MAX)), TIME_W'(rand_upto(TS_MAX)));
        end else begin
            queue_stamps($urandom_range(0, 1) ? TIME_W'(TS_MAX) : '0,
                         $urandom_range(0, 1) ? TIME_W'(TS_MAX) : '0);
        end
    endtask

    function automatic logic [TIME_W-1:0] pick_bound();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return TIME_W'(TS_MAX);
            2: return TIME_W'($urandom_range(0, 300));
            3: return TIME_W'($urandom_range(0, 10000));
            4: return TIME_W'(rand_upto(TS_MAX));
            default: return TIME_W'($urandom_range(0, 100000));
        endcase
    endfunction

    function automatic logic [MIN_W-1:0] pick_min();
        case ($urandom_range(0, 3))
            0: return MIN_W'(1);
            1: return MIN_W'(MAX_SAMPLES);
            2: return MIN_W'($urandom_range(1, 20));
            default: return MIN_W'($urandom_range(1, MAX_SAMPLES));
        endcase
    endfunction

    task automatic write_regs(logic [TIME_W-1:0] mx, logic [TIME_W-1:0] nr,
                              logic [MIN_W-1:0] mn);
        t_cfg_idx idx;
        idx = CFG_MAX_OFFSET;
        repeat (3) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_MAX_OFFSET:  cfg_data <= mx;
                CFG_NEAR_OFFSET: cfg_data <= nr;
                default:         cfg_data <= TIME_W'(mn);
            endcase
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                CFG_MAX_OFFSET:  lim_max_ofs = mx;
                CFG_NEAR_OFFSET: lim_near_ofs = nr;
                default:         lim_min_cnt = mn;
            endcase
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        cfg_settings++;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_stamps.size() != 0 || s_tvalid || expected_reports.size() != 0);
    endtask

    initial begin
        int batch;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: agreeing sample present, limits hit exactly, equal offsets.
        queue_stamps('0, '0);
        queue_offset(5000);
        queue_offset(6000);
        queue_offset(100);
        queue_offset(7000);
        queue_stamps(TIME_W'(TS_MAX), '0);
        queue_stamps('0, TIME_W'(TS_MAX));
        queue_offset(-4200);
        queue_offset(4200);
        queue_offset(4199);
        queue_offset(-4199);
        queue_offset(299);
        queue_offset(-300);
        queue_offset(299);
        queue_offset(299);
        wait_drained();

        // No sample can agree now, so the first applied median raises the warning once.
        write_regs('0, '0, '0);
        queue_offset(1);
        queue_stamps(TIME_W'(TS_MAX), TIME_W'(TS_MAX));
        queue_offset(-1);
        queue_offset(20000);
        wait_drained();

        write_regs(TIME_W'(TS_MAX), TIME_W'(TS_MAX), MIN_W'(MAX_SAMPLES));
        repeat (3) queue_random_sample();
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            write_regs(pick_bound(), pick_bound(), (ph == 0) ? MIN_W'(1) : pick_min());
            tx_steady = (ph == 1 || ph == 7);
            rx_steady = (ph == 1 || ph == 4 || ph == 8);
            batch = (ph < 6) ? 40 : 184;
            repeat (batch) queue_random_sample();
            if (ph == 3) begin
                @(posedge clk);
                long_hold_go <= 1'b1;
                @(posedge clk);
                long_hold_go <= 1'b0;
            end
            wait_drained();
        end

        repeat (600) @(posedge clk);
        $display({"Run covered %0d input words and %0d checked results: ",
                  "%0d samples stored, %0d dropped on a full store."},
                 words_in, results_checked, samples_stored, samples_dropped);
        $display("Register settings applied: %0d; clock mismatch warnings observed: %0d.",
                 cfg_settings, warnings_seen);
        if (bad_results == 0 && expected_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: peer_time_offset_median_unit.f
hw/rtl/pto_pkg.sv
hw/rtl/pto_ram.sv
hw/rtl/pto_cmp.sv
hw/rtl/peer_time_offset_median_unit.sv
sim/tb_top.sv
